// ===== rtl/lma_pkg.sv =====
// ----------------------------------------------------------------------------
// lma_pkg
// shared types, constants and helpers for the langevin middle atom update
// ----------------------------------------------------------------------------
package lma_pkg;

  localparam int ATOMS_DEF = 4096;

  // pipeline schedule, in stages after the input register
  localparam int SQ_N    = 32;
  localparam int ST_AMP  = SQ_N + 2;
  localparam int ST_NPN  = ST_AMP + 4;
  localparam int ST_OLD  = ST_NPN + 1;
  localparam int ST_LAST = ST_OLD + 2;

  localparam logic [1:0] CMD_KICK  = 2'd0;
  localparam logic [1:0] CMD_DRIFT = 2'd1;
  localparam logic [1:0] CMD_CORR  = 2'd2;

  localparam logic [2:0] CFG_STEP_DT     = 3'd0;
  localparam logic [2:0] CFG_HALF_DT     = 3'd1;
  localparam logic [2:0] CFG_INV_DT      = 3'd2;
  localparam logic [2:0] CFG_VEL_SCALE   = 3'd3;
  localparam logic [2:0] CFG_NOISE_SCALE = 3'd4;
  localparam logic [2:0] CFG_THERMAL     = 3'd5;

  localparam logic [15:0] RST_STEP_DT     = 16'd131;
  localparam logic [15:0] RST_HALF_DT     = 16'd66;
  localparam logic [31:0] RST_INV_DT      = 32'd32768000;
  localparam logic [16:0] RST_VEL_SCALE   = 17'd65405;
  localparam logic [16:0] RST_NOISE_SCALE = 17'd4141;
  localparam logic [31:0] RST_THERMAL     = 32'd163457;

  typedef struct packed {
    logic [1:0]         command;
    logic [11:0]        atom_index;
    logic [31:0]        inv_mass;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [15:0] noise_x;
    logic signed [15:0] noise_y;
    logic signed [15:0] noise_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic               updated;
  } out_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [11:0] idx;
    logic        in_range;
    logic        im_nz;
  } ctl_t;

  typedef struct packed {
    logic signed [31:0] kick;
    logic signed [31:0] nvn;
    logic signed [31:0] npn;
    logic signed [31:0] corr;
    logic signed [31:0] vel;
    logic signed [31:0] pos;
  } lane_res_t;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
    if (x > 72'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -72'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

endpackage

// ===== rtl/lma_pipe.sv =====
// ----------------------------------------------------------------------------
// lma_pipe
// stall-aware delay line that keeps side data aligned with the datapath
// ----------------------------------------------------------------------------
module lma_pipe #(
  parameter int W = 32,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);
  logic [W-1:0] tap_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= din;
      for (int i = 1; i < N; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign dout = tap_r[N-1];
endmodule

// ===== rtl/lma_sqrt.sv =====
// ----------------------------------------------------------------------------
// lma_sqrt
// pipelined integer square root, two radicand bits per stage
// ----------------------------------------------------------------------------
module lma_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad,
  output logic [31:0] root
);
  import lma_pkg::*;

  logic [63:0] rad_r  [SQ_N];
  logic [35:0] rem_r  [SQ_N];
  logic [31:0] root_r [SQ_N];

  for (genvar s = 0; s < SQ_N; s++) begin : g_st
    logic [63:0] rad_in;
    logic [35:0] rem_in;
    logic [31:0] root_in;
    logic [35:0] rem4;
    logic [35:0] trial;

    if (s == 0) begin : g_first
      assign rad_in  = rad;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
    end

    always_comb begin
      rem4  = {rem_in[33:0], rad_in[63:62]};
      trial = {2'b00, root_in, 2'b01};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[s] <= {rad_in[61:0], 2'b00};
        if (rem4 >= trial) begin
          rem_r[s]  <= rem4 - trial;
          root_r[s] <= {root_in[30:0], 1'b1};
        end else begin
          rem_r[s]  <= rem4;
          root_r[s] <= {root_in[30:0], 1'b0};
        end
      end
    end
  end

  assign root = root_r[SQ_N-1];
endmodule

// ===== rtl/lma_lane.sv =====
// ----------------------------------------------------------------------------
// lma_lane
// one coordinate axis: kick, damp and noise, both drifts, correction
// ----------------------------------------------------------------------------
module lma_lane (
  input  logic                       clk,
  input  logic                       en,
  input  logic [15:0]                half_dt,
  input  logic [16:0]                vel_scale,
  input  logic [31:0]                inv_dt,
  input  logic signed [31:0]         vel,
  input  logic signed [31:0]         pos,
  input  logic signed [15:0]         noise,
  input  logic [31:0]                kick_a,
  input  logic [32:0]                amp,
  input  logic signed [31:0]         old,
  output logic signed [31:0]         npn_early,
  output lma_pkg::lane_res_t         res
);
  import lma_pkg::*;

  logic signed [48:0] pd1_r;
  logic signed [49:0] pdamp_r;
  logic signed [31:0] p1_r, v1_r, v2_r;
  logic signed [64:0] pk_r;
  logic signed [31:0] x1_r, kick_r;
  logic signed [33:0] damp_r;
  logic signed [49:0] pn_r;
  logic signed [31:0] nvn_r, npn_r, corr_r;
  logic signed [48:0] pd2_r;
  logic signed [65:0] pc_r;

  logic signed [15:0] n_d;
  logic signed [33:0] damp_d;
  logic signed [31:0] x1_d, p_d, v_d;

  logic signed [32:0] d1_c, d2_c, diff_c;
  logic signed [33:0] x1s_c, nps_c;
  logic signed [48:0] kd_c;
  logic signed [49:0] ks_c, cd_c;
  logic signed [37:0] nd_c;
  logic signed [38:0] ns_c;
  logic signed [50:0] cs_c;

  always_comb begin
    d1_c   = 33'((pd1_r + 49'sd32768) >>> 16);
    x1s_c  = 34'(p1_r) + 34'(d1_c);
    kd_c   = 49'((pk_r + 65'sd32768) >>> 16);
    ks_c   = 50'(v2_r) + 50'(kd_c);
    nd_c   = 38'((pn_r + 50'sd2048) >>> 12);
    ns_c   = 39'(damp_d) + 39'(nd_c);
    d2_c   = 33'((pd2_r + 49'sd32768) >>> 16);
    nps_c  = 34'(x1_d) + 34'(d2_c);
    diff_c = 33'(p_d) - 33'(old);
    cd_c   = 50'((pc_r + 66'sd32768) >>> 16);
    cs_c   = 51'(v_d) + 51'(cd_c);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pd1_r   <= vel * $signed({1'b0, half_dt});
      pdamp_r <= vel * $signed({1'b0, vel_scale});
      p1_r    <= pos;
      v1_r    <= vel;
      v2_r    <= v1_r;
      pk_r    <= $signed({1'b0, kick_a}) * p1_r;
      x1_r    <= sat32(72'(x1s_c));
      damp_r  <= 34'((pdamp_r + 50'sd32768) >>> 16);
      kick_r  <= sat32(72'(ks_c));
      pn_r    <= $signed({1'b0, amp}) * n_d;
      nvn_r   <= sat32(72'(ns_c));
      pd2_r   <= nvn_r * $signed({1'b0, half_dt});
      npn_r   <= sat32(72'(nps_c));
      pc_r    <= diff_c * $signed({1'b0, inv_dt});
      corr_r  <= sat32(72'(cs_c));
    end
  end

  lma_pipe #(.W(16), .N(ST_AMP)) u_n (
    .clk(clk), .en(en), .din(noise), .dout(n_d));
  lma_pipe #(.W(34), .N(ST_AMP - 1)) u_damp (
    .clk(clk), .en(en), .din(damp_r), .dout(damp_d));
  lma_pipe #(.W(32), .N(ST_NPN - 3)) u_x1 (
    .clk(clk), .en(en), .din(x1_r), .dout(x1_d));
  lma_pipe #(.W(32), .N(ST_OLD)) u_p (
    .clk(clk), .en(en), .din(pos), .dout(p_d));
  lma_pipe #(.W(32), .N(ST_OLD + 1)) u_v (
    .clk(clk), .en(en), .din(vel), .dout(v_d));

  lma_pipe #(.W(32), .N(ST_LAST - 3)) u_kick_o (
    .clk(clk), .en(en), .din(kick_r), .dout(res.kick));
  lma_pipe #(.W(32), .N(ST_LAST - ST_AMP - 2)) u_nvn_o (
    .clk(clk), .en(en), .din(nvn_r), .dout(res.nvn));
  lma_pipe #(.W(32), .N(ST_LAST - ST_NPN)) u_npn_o (
    .clk(clk), .en(en), .din(npn_r), .dout(res.npn));
  lma_pipe #(.W(32), .N(ST_LAST - ST_OLD)) u_p_o (
    .clk(clk), .en(en), .din(p_d), .dout(res.pos));
  lma_pipe #(.W(32), .N(ST_LAST - ST_OLD - 1)) u_v_o (
    .clk(clk), .en(en), .din(v_d), .dout(res.vel));

  assign res.corr  = corr_r;
  assign npn_early = npn_r;
endmodule

// ===== rtl/lma_store.sv =====
// ----------------------------------------------------------------------------
// lma_store
// old position memory, one write and one registered read per cycle while en is high
// ----------------------------------------------------------------------------
module lma_store #(
  parameter int ATOMS = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [95:0]   wdata,
  input  logic          rd_ok,
  output logic [95:0]   rdata
);
  logic [95:0] mem [ATOMS];
  logic [95:0] rd_r;
  logic        ok_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rd_r <= mem[addr];
      ok_r <= rd_ok;
    end
  end

  assign rdata = ok_r ? rd_r : '0;
endmodule

// ===== rtl/lma_merge.sv =====
// ----------------------------------------------------------------------------
// lma_merge
// picks each axis result by phase and registers the output transfer
// ----------------------------------------------------------------------------
module lma_merge (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld,
  input  lma_pkg::ctl_t      ctl,
  input  lma_pkg::lane_res_t res [3],
  output logic               out_valid,
  output lma_pkg::out_t      out_data
);
  import lma_pkg::*;

  logic signed [31:0] nv_c [3];
  logic signed [31:0] np_c [3];
  logic               upd_c;
  logic               out_valid_r;
  out_t               out_r;

  always_comb begin
    upd_c = 1'b0;
    for (int k = 0; k < 3; k++) begin
      nv_c[k] = res[k].vel;
      np_c[k] = '0;
      case (ctl.cmd)
        CMD_KICK: begin
          if (ctl.im_nz) nv_c[k] = res[k].kick;
        end
        CMD_DRIFT: begin
          np_c[k] = ctl.im_nz ? res[k].npn : res[k].pos;
          if (ctl.im_nz) nv_c[k] = res[k].nvn;
        end
        CMD_CORR: begin
          np_c[k] = res[k].pos;
          if (ctl.im_nz) nv_c[k] = res[k].corr;
        end
        default: ;
      endcase
    end
    case (ctl.cmd) inside
      CMD_KICK, CMD_DRIFT, CMD_CORR: upd_c = ctl.im_nz;
      default: upd_c = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= '{new_vel_x: nv_c[0], new_vel_y: nv_c[1], new_vel_z: nv_c[2],
                 new_pos_x: np_c[0], new_pos_y: np_c[1], new_pos_z: np_c[2],
                 updated: upd_c};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule

// ===== rtl/langevin_middle_atom_update.sv =====
// ----------------------------------------------------------------------------
// langevin_middle_atom_update
// per-atom kick, drift-noise-drift and correction for a langevin middle step
//
//   channel  dir  handshake            payload
//   in_      in   in_valid/in_ready    lma_pkg::in_t
//   out_     out  out_valid/out_ready  lma_pkg::out_t
//   cfg_     in   cfg_we               cfg_index, cfg_wdata
//
// one atom per cycle unless the output stalls; the pipeline length is
// set by the 32-stage square root that feeds the noise amplitude
// synchronous reset restores register defaults; old positions stay unset
// when out_valid is held without out_ready the whole pipeline holds
// ----------------------------------------------------------------------------
module langevin_middle_atom_update #(
  parameter int ATOMS = lma_pkg::ATOMS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lma_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output lma_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_wdata
);
  import lma_pkg::*;

  localparam int AW = (ATOMS > 1) ? $clog2(ATOMS) : 1;

  logic [15:0] step_dt_r, half_dt_r;
  logic [31:0] inv_dt_r, thermal_r;
  logic [16:0] vel_scale_r, noise_scale_r;

  logic              en;
  in_t               in_r;
  logic [ST_LAST:0]  vld_r;
  logic [31:0]       a_r;
  logic [63:0]       rad_r;
  logic [31:0]       sigma;
  logic [32:0]       amp_r;
  logic [47:0]       ap_c;
  logic [48:0]       amp_c;
  ctl_t              ctl0, ctl_npn, ctl_last;

  logic signed [31:0] vel_a [3];
  logic signed [31:0] pos_a [3];
  logic signed [15:0] noi_a [3];
  logic signed [31:0] old_a [3];
  logic signed [31:0] npn_a [3];
  lane_res_t          res_a [3];
  logic [95:0]        old_w;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_dt_r     <= RST_STEP_DT;
      half_dt_r     <= RST_HALF_DT;
      inv_dt_r      <= RST_INV_DT;
      vel_scale_r   <= RST_VEL_SCALE;
      noise_scale_r <= RST_NOISE_SCALE;
      thermal_r     <= RST_THERMAL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEP_DT:     step_dt_r     <= cfg_wdata[15:0];
        CFG_HALF_DT:     half_dt_r     <= cfg_wdata[15:0];
        CFG_INV_DT:      inv_dt_r      <= cfg_wdata;
        CFG_VEL_SCALE:   vel_scale_r   <= cfg_wdata[16:0];
        CFG_NOISE_SCALE: noise_scale_r <= cfg_wdata[16:0];
        CFG_THERMAL:     thermal_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[ST_LAST-1:0], in_valid};
    end
  end

  always_comb begin
    ap_c  = 48'(step_dt_r) * 48'(in_r.inv_mass);
    amp_c = 49'(noise_scale_r) * 49'(sigma);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_r  <= in_data;
      a_r   <= 32'((ap_c + 48'd32768) >> 16);
      rad_r <= 64'(thermal_r) * 64'(in_r.inv_mass);
      amp_r <= 33'((amp_c + 49'd32768) >> 16);
    end
  end

  lma_sqrt u_sqrt (.clk(clk), .en(en), .rad(rad_r), .root(sigma));

  always_comb begin
    ctl0.cmd      = in_r.command;
    ctl0.idx      = in_r.atom_index;
    ctl0.in_range = 32'(in_r.atom_index) < 32'(ATOMS);
    ctl0.im_nz    = in_r.inv_mass != '0;
  end

  lma_pipe #(.W($bits(ctl_t)), .N(ST_NPN)) u_ctl_a (
    .clk(clk), .en(en), .din(ctl0), .dout(ctl_npn));
  lma_pipe #(.W($bits(ctl_t)), .N(ST_LAST - ST_NPN)) u_ctl_b (
    .clk(clk), .en(en), .din(ctl_npn), .dout(ctl_last));

  assign vel_a = '{in_r.vel_x, in_r.vel_y, in_r.vel_z};
  assign pos_a = '{in_r.vec_x, in_r.vec_y, in_r.vec_z};
  assign noi_a = '{in_r.noise_x, in_r.noise_y, in_r.noise_z};
  assign old_a = '{old_w[31:0], old_w[63:32], old_w[95:64]};

  for (genvar k = 0; k < 3; k++) begin : g_lane
    lma_lane u_lane (
      .clk(clk), .en(en), .half_dt(half_dt_r), .vel_scale(vel_scale_r),
      .inv_dt(inv_dt_r), .vel(vel_a[k]), .pos(pos_a[k]), .noise(noi_a[k]),
      .kick_a(a_r), .amp(amp_r), .old(old_a[k]), .npn_early(npn_a[k]),
      .res(res_a[k]));
  end

  lma_store #(.ATOMS(ATOMS), .AW(AW)) u_store (
    .clk(clk), .en(en),
    .we(vld_r[ST_NPN] && ctl_npn.cmd == CMD_DRIFT && ctl_npn.im_nz
        && ctl_npn.in_range),
    .addr(AW'(ctl_npn.idx)),
    .wdata({npn_a[2], npn_a[1], npn_a[0]}),
    .rd_ok(ctl_npn.in_range),
    .rdata(old_w));

  lma_merge u_merge (
    .clk(clk), .rst_n(rst_n), .en(en), .vld(vld_r[ST_LAST]), .ctl(ctl_last),
    .res(res_a), .out_valid(out_valid), .out_data(out_data));
endmodule

// ===== rtl/lma_checker.sv =====
// ----------------------------------------------------------------------------
// lma_checker
// port-level checks on the atom update, bound to the top level
// ----------------------------------------------------------------------------
module lma_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input lma_pkg::out_t out_data
);
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped during stall");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("out_data changed during stall");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid after reset");
endmodule

bind langevin_middle_atom_update lma_checker u_lma_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .out_data(out_data));

// ===== tb/sv/langevin_middle_atom_update_test.sv =====
// ----------------------------------------------------------------------------
// langevin_middle_atom_update_test
// self-checking bench for the per-atom langevin middle update: directed
// corner items, register sweeps, random kick/drift/correction sequences,
// long output backpressure and a drain pause, each result checked in order
// against a fixed-point predictor kept inside the bench
// ----------------------------------------------------------------------------
module langevin_middle_atom_update_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lma_pkg::*;

  localparam int NUM_ATOMS   = 4096;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  in_t           in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  out_t          out_data;
  logic          cfg_we = 1'b0;
  logic [2:0]    cfg_index = '0;
  logic [31:0]   cfg_wdata = '0;

  // predictor copy of the registers and the old-position store
  longint        step_dt, half_dt, inv_dt, vel_scale, noise_scale, thermal;
  logic signed [31:0] old_pos [NUM_ATOMS][3];
  bit            old_valid [NUM_ATOMS];
  out_t          expected_q[$];

  int            mismatches = 0;
  int            quiet_cycles = 0;
  bit            idle_en = 1'b1;
  bit            hold_req = 1'b0;
  int            hold_cnt = 0;
  int            stall_cnt = 0;

  langevin_middle_atom_update uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic longint rnd_shift(longint x, int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint half_drift(longint x, longint v);
    return longint'(clamp32(x + rnd_shift(v * half_dt, 16)));
  endfunction

  function automatic longint corr_term(longint d);
    longint unsigned m, q, bias;
    m = (d < 0) ? longint'(-d) : d;
    bias = (d < 0) ? 32767 : 32768;
    q = m * (inv_dt >> 16) + ((m * (inv_dt & 16'hffff) + bias) >> 16);
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  // expected result of one atom; updates the old-position store
  function automatic out_t atom_update(in_t it);
    out_t r;
    longint v[3], p[3], nz[3], nv[3], np[3];
    longint a, amp, x1, damp, old;
    longint unsigned sigma;
    longint im;
    im = it.inv_mass;
    v = '{it.vel_x, it.vel_y, it.vel_z};
    p = '{it.vec_x, it.vec_y, it.vec_z};
    nz = '{it.noise_x, it.noise_y, it.noise_z};
    nv = v;
    np = '{0, 0, 0};
    r.updated = 1'b0;
    case (it.command)
      CMD_KICK: begin
        if (im != 0) begin
          a = (step_dt * im + 32768) >>> 16;
          for (int k = 0; k < 3; k++) nv[k] = clamp32(v[k] + rnd_shift(a * p[k], 16));
          r.updated = 1'b1;
        end
      end
      CMD_DRIFT: begin
        if (im == 0) begin
          np = p;
        end else begin
          sigma = int_sqrt(longint'(thermal) * longint'(im));
          amp = (noise_scale * longint'(sigma) + 32768) >>> 16;
          for (int k = 0; k < 3; k++) begin
            x1 = half_drift(p[k], v[k]);
            damp = rnd_shift(vel_scale * v[k], 16);
            nv[k] = clamp32(damp + rnd_shift(amp * nz[k], 12));
            np[k] = half_drift(x1, nv[k]);
            old_pos[it.atom_index][k] = np[k][31:0];
          end
          old_valid[it.atom_index] = 1'b1;
          r.updated = 1'b1;
        end
      end
      CMD_CORR: begin
        np = p;
        if (im != 0) begin
          for (int k = 0; k < 3; k++) begin
            old = old_pos[it.atom_index][k];
            nv[k] = clamp32(v[k] + corr_term(p[k] - old));
          end
          r.updated = 1'b1;
        end
      end
      default: ;
    endcase
    r.new_vel_x = nv[0][31:0];
    r.new_vel_y = nv[1][31:0];
    r.new_vel_z = nv[2][31:0];
    r.new_pos_x = np[0][31:0];
    r.new_pos_y = np[1][31:0];
    r.new_pos_z = np[2][31:0];
    return r;
  endfunction

  // one transfer on the input channel, with an optional idle burst first
  task automatic send_atom(in_t it);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(atom_update(it));
    @(negedge clk);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    stop_sending();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      CFG_STEP_DT:     step_dt = val[15:0];
      CFG_HALF_DT:     half_dt = val[15:0];
      CFG_INV_DT:      inv_dt = val;
      CFG_VEL_SCALE:   vel_scale = val[16:0];
      CFG_NOISE_SCALE: noise_scale = val[16:0];
      CFG_THERMAL:     thermal = val;
      default: ;
    endcase
  endtask

  task automatic cfg_all(logic [31:0] sdt, logic [31:0] hdt, logic [31:0] idt,
                         logic [31:0] vs, logic [31:0] ns, logic [31:0] kt);
    cfg_write(CFG_STEP_DT, sdt);
    cfg_write(CFG_HALF_DT, hdt);
    cfg_write(CFG_INV_DT, idt);
    cfg_write(CFG_VEL_SCALE, vs);
    cfg_write(CFG_NOISE_SCALE, ns);
    cfg_write(CFG_THERMAL, kt);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      3: return 32'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
      default: return 32'(int'($urandom_range(0, 1 << 26)) - (1 << 25));
    endcase
  endfunction

  function automatic logic [31:0] rand_mass();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hffffffff;
      2: return $urandom;
      default: return $urandom_range(1 << 10, 1 << 20);
    endcase
  endfunction

  function automatic in_t rand_atom(logic [1:0] cmd, logic [11:0] idx);
    in_t it;
    it.command    = cmd;
    it.atom_index = idx;
    it.inv_mass   = rand_mass();
    it.vel_x = rand_word();
    it.vel_y = rand_word();
    it.vel_z = rand_word();
    it.vec_x = rand_word();
    it.vec_y = rand_word();
    it.vec_z = rand_word();
    it.noise_x = 16'($urandom);
    it.noise_y = 16'($urandom);
    it.noise_z = 16'($urandom);
    return it;
  endfunction

  function automatic logic [11:0] rand_index();
    return ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 31));
  endfunction

  // kick, drift-noise-drift, correction on one atom, mostly near the drifted spot
  task automatic send_step(logic [11:0] idx);
    in_t it;
    it = rand_atom(CMD_KICK, idx);
    send_atom(it);
    it = rand_atom(CMD_DRIFT, idx);
    if (it.inv_mass == 0) it.inv_mass = $urandom_range(1, 1 << 20);
    send_atom(it);
    it = rand_atom(CMD_CORR, idx);
    if ($urandom_range(0, 3) != 0) begin
      it.vec_x = old_pos[idx][0] + 32'(int'($urandom_range(0, 4096)) - 2048);
      it.vec_y = old_pos[idx][1] + 32'(int'($urandom_range(0, 4096)) - 2048);
      it.vec_z = old_pos[idx][2] + 32'(int'($urandom_range(0, 4096)) - 2048);
    end
    send_atom(it);
  endtask

  task automatic send_random_atom();
    in_t it;
    it = rand_atom(2'($urandom_range(0, 3)), rand_index());
    if (it.command == CMD_CORR && !old_valid[it.atom_index]) it.command = CMD_DRIFT;
    send_atom(it);
  endtask

  task automatic run_mix(int n);
    for (int i = 0; i < n; ) begin
      if ($urandom_range(0, 9) < 7) begin
        send_step(rand_index());
        i += 3;
      end else begin
        send_random_atom();
        i++;
      end
    end
  endtask

  task automatic test_directed();
    in_t it;
    it = '0;
    it.command = CMD_DRIFT; it.atom_index = 12'd0; it.inv_mass = 32'hffffffff;
    it.vel_x = 32'sh7fffffff; it.vel_y = 32'sh80000000; it.vel_z = 32'sd0;
    it.vec_x = 32'sh7fffffff; it.vec_y = 32'sh80000000; it.vec_z = 32'sd65536;
    it.noise_x = 16'sh7fff; it.noise_y = 16'sh8000; it.noise_z = 16'sd0;
    send_atom(it);
    it.atom_index = 12'hfff; it.noise_x = 16'sh8000; it.noise_y = 16'sh7fff;
    send_atom(it);
    it.command = CMD_KICK;
    send_atom(it);
    it.inv_mass = 32'd0;
    send_atom(it);
    it.command = CMD_DRIFT;
    send_atom(it);
    it.command = CMD_CORR;
    send_atom(it);
    it.command = CMD_UNUSED; it.inv_mass = 32'd65536;
    send_atom(it);
    it.command = CMD_CORR; it.atom_index = 12'd0;
    it.vec_x = 32'sh80000000; it.vec_y = 32'sh7fffffff; it.inv_mass = 32'hffffffff;
    send_atom(it);
    it.atom_index = 12'hfff; it.inv_mass = 32'd1;
    send_atom(it);
    it.command = CMD_KICK; it.inv_mass = 32'd1; it.vec_x = 32'sd1;
    send_atom(it);
    for (int i = 0; i < 4; i++) send_step(12'(i + 1));
  endtask

  task automatic test_config_sweep();
    wait_drained();
    cfg_all(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
            32'hffffffff);
    run_mix(40);
    wait_drained();
    cfg_all(0, 0, 0, 0, 0, 0);
    run_mix(30);
    wait_drained();
    cfg_all(65535, 32768, 32'd65536, 65536, 65536, 32'd65536);
    run_mix(40);
    wait_drained();
    cfg_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    run_mix(40);
    wait_drained();
    cfg_all(131, 66, 32768000, 65405, 4141, 163457);
  endtask

  task automatic test_random();
    run_mix(900);
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    run_mix(150);
  endtask

  task automatic test_drain_pause();
    wait_drained();
    run_mix(60);
  endtask

  task automatic test_no_idle();
    idle_en = 1'b0;
    run_mix(100);
  endtask

  // result side: random stalls and one long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      out_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      stall_cnt = $urandom_range(0, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t %s expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t unexpected transfer, expected none actual %h", $time, out_data);
      end else begin
        e = expected_q.pop_front();
        check_field("new_vel_x", e.new_vel_x, out_data.new_vel_x);
        check_field("new_vel_y", e.new_vel_y, out_data.new_vel_y);
        check_field("new_vel_z", e.new_vel_z, out_data.new_vel_z);
        check_field("new_pos_x", e.new_pos_x, out_data.new_pos_x);
        check_field("new_pos_y", e.new_pos_y, out_data.new_pos_y);
        check_field("new_pos_z", e.new_pos_z, out_data.new_pos_z);
        check_field("updated", 32'(e.updated), 32'(out_data.updated));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    step_dt = RST_STEP_DT;
    half_dt = RST_HALF_DT;
    inv_dt = RST_INV_DT;
    vel_scale = RST_VEL_SCALE;
    noise_scale = RST_NOISE_SCALE;
    thermal = RST_THERMAL;
    for (int i = 0; i < NUM_ATOMS; i++) begin
      old_valid[i] = 1'b0;
      old_pos[i] = '{0, 0, 0};
    end
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_config_sweep();
    test_random();
    test_backpressure();
    test_drain_pause();
    test_no_idle();
    wait_drained();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lma_pkg.sv
rtl/lma_pipe.sv
rtl/lma_sqrt.sv
rtl/lma_lane.sv
rtl/lma_store.sv
rtl/lma_merge.sv
rtl/langevin_middle_atom_update.sv
rtl/lma_checker.sv
tb/sv/langevin_middle_atom_update_test.sv
